// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define FEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FEXP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fexp_pkg.sv -----
package fexp_pkg;

  localparam int NUM_STAGES = 21;
  localparam int STG_W      = 5;

  localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
  localparam logic [31:0] PINF_BITS = 32'h7F800000;
  localparam logic [31:0] OVF_BITS  = 32'h42B17218;  // 88.722839
  localparam logic [31:0] UNF_MAG   = 32'h42CFF1B5;  // magnitude of -103.972084

  localparam logic [31:0] INV_LN2 = 32'h3FB8AA3B;
  localparam logic [31:0] BIAS    = 32'h4B400000;
  localparam logic [31:0] LN2_HI  = 32'h3F317200;
  localparam logic [31:0] LN2_LO  = 32'h35BFBE8E;
  localparam logic [31:0] C6      = 32'h3AB4A000;
  localparam logic [31:0] C5      = 32'h3C092F6E;
  localparam logic [31:0] C4      = 32'h3D2AADAD;
  localparam logic [31:0] C3      = 32'h3E2AAA28;
  localparam logic [31:0] C2      = 32'h3EFFFFFB;
  localparam logic [31:0] ONE     = 32'h3F800000;
  localparam logic [31:0] SC2_LO  = 32'h1F800000;  // 2^-64
  localparam logic [31:0] SC2_HI  = 32'h40000000;  // 2.0

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SC1,
    OP_SC2
  } op_t;

  typedef enum logic [2:0] {
    SRC_ACC,
    SRC_X,
    SRC_KF,
    SRC_F,
    SRC_K
  } src_t;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_KF,
    DST_F
  } dst_t;

  typedef struct packed {
    op_t         op;
    src_t        sa;
    src_t        sb;
    dst_t        dst;
    logic [31:0] k;
  } ctl_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] bits;
  } spec_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] kf;
    logic [31:0] f;
    logic [31:0] acc;
    spec_t       spec;
  } lane_t;

  function automatic ctl_t mk(op_t op, src_t sa, src_t sb, dst_t dst, logic [31:0] k);
    ctl_t c;
    c.op  = op;
    c.sa  = sa;
    c.sb  = sb;
    c.dst = dst;
    c.k   = k;
    return c;
  endfunction

  function automatic ctl_t stage_ctl(logic [STG_W-1:0] i);
    ctl_t c;
    case (i)
      5'd0:    c = mk(OP_MUL, SRC_X,   SRC_K,   DST_ACC, INV_LN2);
      5'd1:    c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, BIAS);
      5'd2:    c = mk(OP_SUB, SRC_ACC, SRC_K,   DST_KF,  BIAS);
      5'd3:    c = mk(OP_MUL, SRC_KF,  SRC_K,   DST_ACC, LN2_HI);
      5'd4:    c = mk(OP_SUB, SRC_X,   SRC_ACC, DST_F,   ONE);
      5'd5:    c = mk(OP_MUL, SRC_KF,  SRC_K,   DST_ACC, LN2_LO);
      5'd6:    c = mk(OP_SUB, SRC_F,   SRC_ACC, DST_F,   ONE);
      5'd7:    c = mk(OP_MUL, SRC_K,   SRC_F,   DST_ACC, C6);
      5'd8:    c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, C5);
      5'd9:    c = mk(OP_MUL, SRC_ACC, SRC_F,   DST_ACC, ONE);
      5'd10:   c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, C4);
      5'd11:   c = mk(OP_MUL, SRC_ACC, SRC_F,   DST_ACC, ONE);
      5'd12:   c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, C3);
      5'd13:   c = mk(OP_MUL, SRC_ACC, SRC_F,   DST_ACC, ONE);
      5'd14:   c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, C2);
      5'd15:   c = mk(OP_MUL, SRC_ACC, SRC_F,   DST_ACC, ONE);
      5'd16:   c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, ONE);
      5'd17:   c = mk(OP_MUL, SRC_ACC, SRC_F,   DST_ACC, ONE);
      5'd18:   c = mk(OP_ADD, SRC_ACC, SRC_K,   DST_ACC, ONE);
      5'd19:   c = mk(OP_SC1, SRC_ACC, SRC_K,   DST_ACC, ONE);
      5'd20:   c = mk(OP_SC2, SRC_ACC, SRC_K,   DST_ACC, ONE);
      default: c = mk(OP_SC2, SRC_ACC, SRC_K,   DST_ACC, ONE);
    endcase
    return c;
  endfunction

  // Single-precision multiply, round to nearest even. Subnormal operands
  // read as zero; subnormal and infinite results are produced properly.
  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic               s;
    logic [23:0]        ma, mb;
    logic [47:0]        p, m;
    logic signed [10:0] e, d1;
    logic [5:0]         sh;
    logic [95:0]        ext;
    logic [7:0]         ef;
    logic [22:0]        fr;
    logic               g, st, up;
    logic [30:0]        mag;
    s   = a[31] ^ b[31];
    ma  = {1'b1, a[22:0]};
    mb  = {1'b1, b[22:0]};
    p   = ma * mb;
    m   = p[47] ? p : {p[46:0], 1'b0};
    e   = $signed({3'b000, a[30:23]}) + $signed({3'b000, b[30:23]})
          - (p[47] ? 11'sd126 : 11'sd127);
    d1  = 11'sd1 - e;
    sh  = (e >= 11'sd1) ? 6'd0 : ((d1 > 11'sd48) ? 6'd48 : d1[5:0]);
    ext = {m, 48'b0} >> sh;
    ef  = (e >= 11'sd1) ? e[7:0] : 8'd0;
    fr  = ext[94:72];
    g   = ext[71];
    st  = |ext[70:0];
    up  = g & (st | fr[0]);
    mag = {ef, fr} + {30'b0, up};
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
      return {s, 31'b0};
    end else if (e >= 11'sd255) begin
      return {s, PINF_BITS[30:0]};
    end
    return {s, mag};
  endfunction

  // Single-precision add, round to nearest even, subnormals included.
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] l, sm;
    logic [7:0]  el, es, d, lim, sh, ef;
    logic [23:0] ml, ms;
    logic [4:0]  dc, lz;
    logic [51:0] bx;
    logic [26:0] aa, bb, n;
    logic [27:0] sum;
    logic [8:0]  e;
    logic [22:0] fr;
    logic        g, st, up;
    logic [30:0] mag;
    if (a[30:0] >= b[30:0]) begin
      l  = a;
      sm = b;
    end else begin
      l  = b;
      sm = a;
    end
    el  = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
    es  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    ml  = {|l[30:23], l[22:0]};
    ms  = {|sm[30:23], sm[22:0]};
    d   = el - es;
    dc  = (d > 8'd28) ? 5'd28 : d[4:0];
    bx  = {ms, 28'b0} >> dc;
    bb  = {bx[51:26], |bx[25:0]};
    aa  = {ml, 3'b000};
    sum = (l[31] == sm[31]) ? ({1'b0, aa} + {1'b0, bb}) : ({1'b0, aa} - {1'b0, bb});
    lz  = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    if (sum[27]) begin
      n   = {sum[27:2], sum[1] | sum[0]};
      e   = {1'b0, el} + 9'd1;
      lim = 8'd0;
      sh  = 8'd0;
    end else begin
      lim = el - 8'd1;
      sh  = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
      n   = sum[26:0] << sh;
      e   = {1'b0, el} - {1'b0, sh};
    end
    ef  = n[26] ? e[7:0] : 8'd0;
    fr  = n[25:3];
    g   = n[2];
    st  = n[1] | n[0];
    up  = g & (st | fr[0]);
    mag = {ef, fr} + {30'b0, up};
    if (sum == 28'd0) begin
      return {l[31] & sm[31], 31'b0};
    end
    return {l[31], mag};
  endfunction

  // Integer value of a float that holds a whole number of small magnitude.
  function automatic logic signed [9:0] kint(logic [31:0] kf);
    logic [7:0]  e;
    logic [23:0] mv;
    logic [8:0]  mag;
    e  = kf[30:23];
    mv = {1'b1, kf[22:0]} >> (8'd150 - e);
    if (e < 8'd127) begin
      mag = 9'd0;
    end else if (e > 8'd134) begin
      mag = 9'd255;
    end else begin
      mag = mv[8:0];
    end
    return kf[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic sc_pass(logic signed [9:0] k);
    return (k >= -10'sd126) && (k <= 10'sd127);
  endfunction

  function automatic logic [31:0] scale1(logic signed [9:0] k);
    logic signed [10:0] t;
    if (k < -10'sd126) begin
      t = $signed({k[9], k}) + 11'sd191;
      if (t < 11'sd1) t = 11'sd1;
    end else if (k > 10'sd127) begin
      t = 11'sd254;
    end else begin
      t = $signed({k[9], k}) + 11'sd127;
    end
    return {1'b0, t[7:0], 23'b0};
  endfunction

  function automatic logic [31:0] scale2(logic signed [9:0] k);
    return (k < -10'sd126) ? SC2_LO : SC2_HI;
  endfunction

endpackage

// ----- hw/rtl/fexp_screen.sv -----
module fexp_screen (
  input  logic [31:0]     x_bits,
  output fexp_pkg::spec_t spec
);

  always_comb begin
    spec.hit  = 1'b0;
    spec.bits = 32'd0;
    if (x_bits[30:0] > fexp_pkg::PINF_BITS[30:0]) begin
      spec.hit  = 1'b1;
      spec.bits = fexp_pkg::QNAN_BITS;
    end else if (!x_bits[31] && x_bits[30:0] > fexp_pkg::OVF_BITS[30:0]) begin
      spec.hit  = 1'b1;
      spec.bits = fexp_pkg::PINF_BITS;
    end else if (x_bits[31] && x_bits[30:0] > fexp_pkg::UNF_MAG[30:0]) begin
      spec.hit  = 1'b1;
      spec.bits = 32'd0;
    end
  end

endmodule

// ----- hw/rtl/fexp_cell.sv -----
module fexp_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  fexp_pkg::ctl_t  ctl,
  input  logic            vld_in,
  input  fexp_pkg::lane_t lane_in,
  output logic            vld_out,
  output fexp_pkg::lane_t lane_out
);

  logic                valid_r, valid_nxt;
  fexp_pkg::lane_t     lane_r, lane_nxt;
  logic [31:0]         opa, opb, res;
  logic signed [9:0]   k_w;

  function automatic logic [31:0] pick(fexp_pkg::src_t s, fexp_pkg::lane_t ln,
                                       logic [31:0] kc);
    logic [31:0] v;
    case (s)
      fexp_pkg::SRC_ACC: v = ln.acc;
      fexp_pkg::SRC_X:   v = ln.x;
      fexp_pkg::SRC_KF:  v = ln.kf;
      fexp_pkg::SRC_F:   v = ln.f;
      fexp_pkg::SRC_K:   v = kc;
      default:           v = kc;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctl.sa, lane_in, ctl.k);
    opb = pick(ctl.sb, lane_in, ctl.k);
    k_w = fexp_pkg::kint(lane_in.kf);
    case (ctl.op)
      fexp_pkg::OP_MUL: res = fexp_pkg::fmul(opa, opb);
      fexp_pkg::OP_ADD: res = fexp_pkg::fadd(opa, opb);
      fexp_pkg::OP_SUB: res = fexp_pkg::fadd(opa, {~opb[31], opb[30:0]});
      fexp_pkg::OP_SC1: res = fexp_pkg::fmul(lane_in.acc, fexp_pkg::scale1(k_w));
      fexp_pkg::OP_SC2: res = fexp_pkg::sc_pass(k_w) ? lane_in.acc
                              : fexp_pkg::fmul(lane_in.acc, fexp_pkg::scale2(k_w));
      default:          res = lane_in.acc;
    endcase
  end

  always_comb begin
    valid_nxt = vld_in;
    lane_nxt  = lane_in;
    case (ctl.dst)
      fexp_pkg::DST_ACC: lane_nxt.acc = res;
      fexp_pkg::DST_KF:  lane_nxt.kf  = res;
      fexp_pkg::DST_F:   lane_nxt.f   = res;
      default:           lane_nxt.acc = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // advance the payload every cycle; valid alone qualifies it
  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign vld_out  = valid_r;
  assign lane_out = lane_r;

endmodule

// ----- hw/rtl/float32_exponential_core.sv -----
// Single-precision e^x, one argument per beat.
//
// Input: raise start with the raw argument on in_x_bits; the beat is taken
// at the edge where start is high and busy is low. busy is high only while
// reset is held, so outside reset a new argument can be given in every
// cycle, back to back without gaps.
// Output: out_valid is high for one cycle with e^x on out_result_bits.
// The receiver cannot hold results off; nothing here waits on it.
// Each rounded multiply or add along the chain (reduction, Horner steps
// and the two scale steps) has its own registered cell; the result is
// read from the last cell. Throughput: one result per cycle.
// Special arguments (NaN, overflow, underflow) are flagged on entry and ride
// the chain beside the arithmetic, so they take as long as any other argument.
// Reset (synchronous, active low) drops every beat in flight; no result
// appears for beats accepted before it.
module float32_exponential_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);

  `include "assert_macros.svh"

  fexp_pkg::lane_t lane_w [0:fexp_pkg::NUM_STAGES];
  logic            vld_w  [0:fexp_pkg::NUM_STAGES];
  fexp_pkg::spec_t spec_w;
  logic            acc_w;
  logic            nan_w;
  logic            nan_res_w;

  assign busy  = !rst_n;
  assign acc_w = start && !busy;

  fexp_screen u_screen (
    .x_bits (in_x_bits),
    .spec   (spec_w)
  );

  always_comb begin
    vld_w[0]      = start && !busy;
    lane_w[0].x   = in_x_bits;
    lane_w[0].kf  = 32'd0;
    lane_w[0].f   = 32'd0;
    lane_w[0].acc = 32'd0;
    lane_w[0].spec = spec_w;
  end

  for (genvar i = 0; i < fexp_pkg::NUM_STAGES; i++) begin : g_cell
    fexp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (fexp_pkg::stage_ctl(fexp_pkg::STG_W'(i))),
      .vld_in   (vld_w[i]),
      .lane_in  (lane_w[i]),
      .vld_out  (vld_w[i+1]),
      .lane_out (lane_w[i+1])
    );
  end

  assign out_valid       = vld_w[fexp_pkg::NUM_STAGES];
  assign out_result_bits = lane_w[fexp_pkg::NUM_STAGES].spec.hit
                         ? lane_w[fexp_pkg::NUM_STAGES].spec.bits
                         : lane_w[fexp_pkg::NUM_STAGES].acc;

  assign nan_w     = acc_w && (in_x_bits[30:0] > fexp_pkg::PINF_BITS[30:0]);
  assign nan_res_w = (out_result_bits == fexp_pkg::QNAN_BITS);

  `FEXP_ASSERT_ALWAYS(a_rst_flush, !rst_n |=> !out_valid, "result beat after reset")
  `FEXP_ASSERT(a_latency, out_valid |-> $past(acc_w, fexp_pkg::NUM_STAGES), "orphan result")
  `FEXP_ASSERT(a_nan, out_valid && $past(nan_w, fexp_pkg::NUM_STAGES) |-> nan_res_w, "NaN lost")
  `FEXP_ASSERT(a_sign, out_valid |-> !out_result_bits[31], "negative e^x result")

endmodule
